FILE: rtl/dvca_pkg.sv
package dvca_pkg;

  localparam int unsigned DimW    = 15;
  localparam int unsigned WeightW = 17;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ValW    = 16;
  localparam int unsigned PriorW  = 32;
  localparam int unsigned SumW    = 40;
  localparam int unsigned NumW    = 33;
  localparam int unsigned DenW    = 17;
  localparam int unsigned QuoW    = 33;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [WeightW-1:0] WeightOne = 17'h10000;

  // Register indexes on the configuration channel
  localparam logic [1:0] RegXDim   = 2'd0;
  localparam logic [1:0] RegYDim   = 2'd1;
  localparam logic [1:0] RegZDim   = 2'd2;
  localparam logic [1:0] RegWeight = 2'd3;

  // Classified voxel handed from front to back
  typedef struct packed {
    logic              reject;
    logic              add;
    logic [NumW-1:0]   num;
    logic [DenW-1:0]   den;
    logic              last;
    logic [PriorW-1:0] prior;
    logic [PriorW:0]   hd;
  } cls_t;

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[SumW] ? SumMax : s[SumW-1:0];
  endfunction

endpackage

FILE: rtl/dvca_front.sv
module dvca_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dvca_pkg::CoordW-1:0]        x_i,
  input  logic [dvca_pkg::CoordW-1:0]        y_i,
  input  logic [dvca_pkg::CoordW-1:0]        z_i,
  input  logic [dvca_pkg::ValW-1:0]          ed_i,
  input  logic [dvca_pkg::ValW-1:0]          es_i,
  input  logic [dvca_pkg::ValW-1:0]          id_i,
  input  logic [dvca_pkg::ValW-1:0]          is_i,
  input  logic                               last_i,
  input  logic [dvca_pkg::PriorW-1:0]        prior_i,
  input  logic [dvca_pkg::PriorW-1:0]        heur_i,
  input  logic [dvca_pkg::PriorW-1:0]        dist_i,
  input  logic [dvca_pkg::DimW-1:0]          xdim_i,
  input  logic [dvca_pkg::DimW-1:0]          ydim_i,
  input  logic [dvca_pkg::DimW-1:0]          zdim_i,
  output logic                               cls_valid_o,
  input  logic                               cls_ready_i,
  output dvca_pkg::cls_t                     cls_o
);
  import dvca_pkg::*;

  logic  in_b, valid_q;
  logic  [2*ValW-1:0] p0_q, p1_q;
  cls_t  cls_q;
  cls_t  cls_d;

  function automatic logic inb(logic [CoordW-1:0] c, logic [DimW-1:0] d);
    inb = !c[CoordW-1] && (c[DimW-1:0] < d);
  endfunction

  assign in_b = inb(x_i, xdim_i) && inb(y_i, ydim_i) && inb(z_i, zdim_i);

  // Classify and form both products in one register stage
  always_comb begin
    cls_d        = '0;
    cls_d.reject = !in_b || (ed_i == '0 && id_i == '0);
    cls_d.add    = !cls_d.reject && es_i != '0 && is_i != '0;
    cls_d.den    = {1'b0, ed_i} + {1'b0, id_i};
    cls_d.last   = last_i;
    cls_d.prior  = prior_i;
    cls_d.hd     = {1'b0, heur_i} + {1'b0, dist_i};
  end

  assign in_ready_o = !valid_q || cls_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cls_q <= cls_d;
      p0_q  <= ed_i * es_i;
      p1_q  <= id_i * is_i;
    end
  end

  always_comb begin
    cls_o     = cls_q;
    cls_o.num = {1'b0, p0_q} + {1'b0, p1_q};
  end
  assign cls_valid_o = valid_q;

endmodule

FILE: rtl/dvca_fifo.sv
module dvca_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  dvca_pkg::cls_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output dvca_pkg::cls_t rd_data_o
);
  import dvca_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  cls_t            mem_q [Depth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != Depth[AW:0];
  assign rd_valid_o = cnt_q != '0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  function automatic logic [AW-1:0] inc(logic [AW-1:0] p);
    inc = (p == AW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= inc(wp_q);
      if (rd) rp_q <= inc(rp_q);
      cnt_q <= cnt_q + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

FILE: rtl/dvca_back.sv
module dvca_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cls_valid_i,
  output logic                            cls_ready_o,
  input  dvca_pkg::cls_t                  cls_i,
  input  logic [dvca_pkg::WeightW-1:0]    weight_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic                            res_ok_o,
  output logic [dvca_pkg::SumW-1:0]       res_total_o,
  output logic [dvca_pkg::SumW-1:0]       res_value_o
);
  import dvca_pkg::*;

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StBlend = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0]      st_q;
  cls_t            c_q;
  logic [SumW-1:0] run_q, total_q;
  logic            inv_q;
  // Restoring divider, one quotient bit a cycle
  logic [NumW-1:0] rem_q, quo_q;
  logic [5:0]      bit_q;
  logic [NumW:0]   trial;
  logic [NumW-1:0] rem_sh;
  // Blend products, 16-bit slices of the 40-bit total and the 33-bit hd sum, accumulated
  logic [1:0]      seg_q;
  logic [WeightW-1:0] w_q, wc_q;
  logic [SumW+WeightW:0] acc_q;
  logic [15:0]     sa, sb;
  logic [SumW+WeightW:0] pp;
  logic [SumW-1:0] run_new, tot_c, val_c;
  logic            ok_q;
  logic [SumW-1:0] rt_q, rv_q;
  logic            rv_valid_q;
  logic            issue;

  assign rem_sh = {rem_q[NumW-2:0], quo_q[NumW-1]};
  assign trial  = {1'b0, rem_sh} - {{(NumW-DenW+1){1'b0}}, c_q.den};
  assign run_new = sat_add(run_q, {{(SumW-NumW){1'b0}}, quo_q});
  assign tot_c   = sat_add(run_q, {{(SumW-PriorW){1'b0}}, c_q.prior});

  always_comb begin
    sa = '0;
    sb = '0;
    case (seg_q)
      2'd0: begin sa = total_q[15:0];  sb = 16'(c_q.hd[15:0]); end
      2'd1: begin sa = total_q[31:16]; sb = 16'(c_q.hd[31:16]); end
      2'd2: begin sa = {8'd0, total_q[39:32]}; sb = {15'd0, c_q.hd[32]}; end
      default: begin sa = '0; sb = '0; end
    endcase
  end

  // One 17x16 product pair a cycle, shifted into place
  always_comb begin
    logic [WeightW+15:0] m0, m1;
    logic [WeightW+16:0] s;
    m0 = w_q * sa;
    m1 = wc_q * sb;
    s  = {1'b0, m0} + {1'b0, m1};
    pp = (SumW+WeightW+1)'(s) << {seg_q, 4'd0};
  end

  assign val_c = (|acc_q[SumW+WeightW:SumW+16]) ? SumMax : acc_q[SumW+15:16];

  assign cls_ready_o = (st_q == StIdle) && !(rv_valid_q && !res_ready_i && cls_i.last);

  // Result leaves the blend once the output register is free
  assign issue = (st_q == StOut) && (seg_q == 2'd3) && (!rv_valid_q || res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      run_q      <= '0;
      inv_q      <= 1'b0;
      rv_valid_q <= 1'b0;
      c_q        <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
      bit_q      <= '0;
      total_q    <= '0;
      w_q        <= '0;
      wc_q       <= '0;
      acc_q      <= '0;
      seg_q      <= '0;
      ok_q       <= 1'b0;
      rt_q       <= '0;
      rv_q       <= '0;
    end else begin
      if (issue) rv_valid_q <= 1'b1;
      else if (res_ready_i) rv_valid_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (cls_valid_i && cls_ready_o) begin
            c_q   <= cls_i;
            quo_q <= cls_i.num;
            rem_q <= '0;
            bit_q <= '0;
            if (cls_i.reject) inv_q <= 1'b1;
            if (cls_i.add) st_q <= StDiv;
            else if (cls_i.last) st_q <= StMul;
          end
        end
        StDiv: begin
          rem_q <= trial[NumW] ? rem_sh : trial[NumW-1:0];
          quo_q <= {quo_q[NumW-2:0], !trial[NumW]};
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'(NumW - 1)) st_q <= StBlend;
        end
        StBlend: begin
          run_q <= run_new;
          st_q  <= c_q.last ? StMul : StIdle;
        end
        StMul: begin
          total_q <= tot_c;
          w_q     <= (weight_i > WeightOne) ? WeightOne : weight_i;
          wc_q    <= WeightOne - ((weight_i > WeightOne) ? WeightOne : weight_i);
          acc_q   <= '0;
          seg_q   <= 2'd0;
          st_q    <= StOut;
        end
        StOut: begin
          if (seg_q != 2'd3) begin
            acc_q <= acc_q + pp;
            seg_q <= seg_q + 2'd1;
          end else if (issue) begin
            ok_q  <= !inv_q;
            rt_q  <= inv_q ? '0 : total_q;
            rv_q  <= inv_q ? '0 : val_c;
            run_q <= '0;
            inv_q <= 1'b0;
            st_q  <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign res_valid_o = rv_valid_q;
  assign res_ok_o    = ok_q;
  assign res_total_o = rt_q;
  assign res_value_o = rv_q;

endmodule

FILE: rtl/deformable_voxel_cost_accumulator.sv
// Deformable voxel cost accumulator.
// Input stream s_axis: one voxel per transaction; tlast marks the final
// voxel of a shape state. Output stream m_axis: one result per state.
// Configuration: cfg_valid_i/cfg_ready_o with register index and data;
// 0..2 grid sizes, 3 Pareto weight (Q1.16).
// A front stage checks bounds and forms the two products, a two-entry queue
// buffers classified voxels, and a back sequencer does the work.
// In the back end a voxel that adds cost runs through the bit-serial
// restoring divider and then an accumulate step; other voxels are only
// taken in. The back end takes no new voxel until it is idle again. A last
// voxel then adds a multiply setup and the blend, whose product is built
// from 16-bit slices, before its result is issued.
// Reset clears the running sum, reject flag, queue and front stage and sets the
// registers to 256, 256, 256 and 0.5. If the receiver stalls, the result
// holds in the output register and the back end stops at the next last
// voxel; the queue and front stage then fill and s_axis_tready drops.
module deformable_voxel_cost_accumulator #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // env_x, env_y, env_z, env_deform, env_sens, ref_deform, ref_sens,
  // prior_cost, heuristic_value, path_distance
  input  logic [207:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // state_valid, total_cost, state_value, zero pad
  output logic [87:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import dvca_pkg::*;

  logic [DimW-1:0]    xdim_q, ydim_q, zdim_q;
  logic [WeightW-1:0] w_q;
  logic  fv, fr, qv, qr;
  cls_t  fc, qc;
  logic  ok;
  logic [SumW-1:0] tot, val;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xdim_q <= DimW'(256);
      ydim_q <= DimW'(256);
      zdim_q <= DimW'(256);
      w_q    <= WeightW'(32768);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegXDim:   xdim_q <= cfg_data_i[DimW-1:0];
        RegYDim:   ydim_q <= cfg_data_i[DimW-1:0];
        RegZDim:   zdim_q <= cfg_data_i[DimW-1:0];
        RegWeight: w_q    <= cfg_data_i[WeightW-1:0];
        default: ;
      endcase
    end
  end

  dvca_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .x_i(s_axis_tdata[15:0]), .y_i(s_axis_tdata[31:16]), .z_i(s_axis_tdata[47:32]),
    .ed_i(s_axis_tdata[63:48]), .es_i(s_axis_tdata[79:64]),
    .id_i(s_axis_tdata[95:80]), .is_i(s_axis_tdata[111:96]),
    .last_i(s_axis_tlast),
    .prior_i(s_axis_tdata[143:112]), .heur_i(s_axis_tdata[175:144]),
    .dist_i(s_axis_tdata[207:176]),
    .xdim_i(xdim_q), .ydim_i(ydim_q), .zdim_i(zdim_q),
    .cls_valid_o(fv), .cls_ready_i(fr), .cls_o(fc)
  );

  dvca_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fc),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qc)
  );

  dvca_back u_back (
    .clk_i, .rst_ni,
    .cls_valid_i(qv), .cls_ready_o(qr), .cls_i(qc), .weight_i(w_q),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_ok_o(ok), .res_total_o(tot), .res_value_o(val)
  );

  assign m_axis_tdata = {7'd0, val, tot, ok};

endmodule

FILE: rtl/dvca_checker.sv
module dvca_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [87:0]  m_axis_tdata
);
  // A stalled result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");

  // Rejected state reports zero cost and value
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[80:1] == '0)
    else $error("rejected state with nonzero cost");

  // Pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[87:81] == '0)
    else $error("pad bits set");
endmodule

bind deformable_voxel_cost_accumulator dvca_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

FILE: bench/deformable_voxel_cost_accumulator_test.sv
`timescale 1ns / 100ps

module deformable_voxel_cost_accumulator_test;
  import dvca_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [15:0] env_flex;
    logic [15:0] env_sens;
    logic [15:0] ref_deform;
    logic [15:0] ref_sens;
    logic        last;
    logic [31:0] prior;
    logic [31:0] heur;
    logic [31:0] travel;
  } voxel_t;

  typedef struct packed {
    logic        state_valid;
    logic [39:0] total_cost;
    logic [39:0] state_value;
  } state_result_t;

  // Keeps its own copy of registers and running state; queues expected results
  class cost_scoreboard;
    logic [14:0]   x_dim, y_dim, z_dim;
    logic [16:0]   weight;
    logic [39:0]   running_cost;
    bit            rejected;
    state_result_t expected_q[$];
    int            mismatches;

    function new();
      x_dim = 15'd256;
      y_dim = 15'd256;
      z_dim = 15'd256;
      weight = 17'd32768;
      running_cost = '0;
      rejected = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        RegXDim:   x_dim = data[14:0];
        RegYDim:   y_dim = data[14:0];
        RegZDim:   z_dim = data[14:0];
        RegWeight: weight = data[16:0];
        default: ;
      endcase
    endfunction

    function bit coord_ok(logic [15:0] c, logic [14:0] dim);
      return !c[15] && (c[14:0] < dim);
    endfunction

    function logic [39:0] sum_sat(logic [39:0] a, logic [39:0] b);
      logic [40:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[40] ? SumMax : s[39:0];
    endfunction

    function void note_voxel(voxel_t v);
      logic [32:0]   num;
      logic [16:0]   den;
      logic [39:0]   total;
      logic [63:0]   w, hd, blend;
      state_result_t r;
      if (!coord_ok(v.x, x_dim) || !coord_ok(v.y, y_dim) || !coord_ok(v.z, z_dim))
        rejected = 1;
      else if (v.env_flex == 0 && v.ref_deform == 0)
        rejected = 1;
      else if (v.env_sens != 0 && v.ref_sens != 0) begin
        num = 33'(v.env_flex) * 33'(v.env_sens) + 33'(v.ref_deform) * 33'(v.ref_sens);
        den = 17'(v.env_flex) + 17'(v.ref_deform);
        running_cost = sum_sat(running_cost, 40'(num / den));
      end
      if (!v.last) return;
      if (rejected) r = '0;
      else begin
        total = sum_sat(running_cost, 40'(v.prior));
        // weight above one clips to one
        w = (weight > 17'd65536) ? 64'd65536 : 64'(weight);
        hd = 64'(v.heur) + 64'(v.travel);
        blend = ((64'd65536 - w) * hd + w * 64'(total)) >> 16;
        r.state_valid = 1'b1;
        r.total_cost = total;
        r.state_value = (blend > 64'(SumMax)) ? SumMax : blend[39:0];
      end
      expected_q.push_back(r);
      running_cost = '0;
      rejected = 0;
    endfunction

    function void check_result(logic [87:0] data);
      state_result_t got, want;
      got.state_valid = data[0];
      got.total_cost = data[40:1];
      got.state_value = data[80:41];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: valid %0d cost %h value %h",
                   got.state_valid, got.total_cost, got.state_value);
        return;
      end
      want = expected_q.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected valid %0d cost %h value %h, got %0d %h %h",
                   want.state_valid, want.total_cost, want.state_value,
                   got.state_valid, got.total_cost, got.state_value);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [87:0]  m_axis_tdata;
  logic         cfg_valid_i = 0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  cost_scoreboard sb = new();
  int unsigned cycles = 0;
  bit calm_sink = 0;

  deformable_voxel_cost_accumulator dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: sample at the falling edge, transaction completes at the next rise
  always @(negedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) calm_sink <= ~calm_sink;
    if (calm_sink) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) < 70) ||
                          (m_axis_tready && $urandom_range(0, 99) < 50);
  end

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a rising edge; returns at the rising edge where the transaction occurred
  task automatic send_voxel(voxel_t v, int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tlast <= v.last;
    s_axis_tdata <= {v.travel, v.heur, v.prior, v.ref_sens, v.ref_deform,
                     v.env_sens, v.env_flex, v.z, v.y, v.x};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_voxel(v);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // hold the source until every expected result is in, then let the back end settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_grid(int unsigned xd, int unsigned yd, int unsigned zd,
                          int unsigned w);
    write_reg(RegXDim, xd);
    write_reg(RegYDim, yd);
    write_reg(RegZDim, zd);
    write_reg(RegWeight, w);
  endtask

  function logic [15:0] pick_coord(logic [14:0] dim);
    if (dim == 0) return 16'($urandom_range(0, 300));
    return 16'($urandom_range(0, dim - 1));
  endfunction

  function logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 255));
      1: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  function voxel_t make_voxel(bit last);
    voxel_t v;
    int unsigned r;
    v.x = pick_coord(sb.x_dim);
    v.y = pick_coord(sb.y_dim);
    v.z = pick_coord(sb.z_dim);
    v.env_flex = pick_value();
    v.env_sens = pick_value();
    v.ref_deform = pick_value();
    v.ref_sens = pick_value();
    if (v.env_flex == 0 && v.ref_deform == 0) v.ref_deform = 16'd1;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      // out of bounds: random raw coordinate or exactly the size
      case ($urandom_range(0, 2))
        0: v.x = $urandom_range(0, 1) ? 16'($urandom) : 16'(sb.x_dim);
        1: v.y = $urandom_range(0, 1) ? 16'($urandom) : 16'(sb.y_dim);
        default: v.z = $urandom_range(0, 1) ? 16'($urandom) : 16'(sb.z_dim);
      endcase
    end else if (r < 7) begin
      v.env_flex = '0;
      v.ref_deform = '0;
    end else if (r < 14) begin
      if ($urandom_range(0, 1)) v.env_sens = '0;
      else v.ref_sens = '0;
    end else if (r < 20) begin
      if ($urandom_range(0, 1)) v.env_flex = '0;
      else v.ref_deform = '0;
    end
    v.last = last;
    v.prior = last ? 32'($urandom) : 32'($urandom);
    v.heur = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 65535)) : 32'($urandom);
    v.travel = 32'($urandom);
    return v;
  endfunction

  task automatic random_states(int unsigned n_items);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int unsigned k = 0; k < len; k++)
        send_voxel(make_voxel(k == len - 1), gap_len());
      sent += len;
    end
  endtask

  function voxel_t vox(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                       logic [15:0] ed, logic [15:0] es, logic [15:0] rd,
                       logic [15:0] rs, bit last);
    voxel_t v;
    v = '{x, y, z, ed, es, rd, rs, last, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    return v;
  endfunction

  initial begin
    voxel_t v;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: extremes, zero sensitivity, rejects, single-deform voxels
    send_voxel(vox(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1), 0);
    send_voxel(vox(255, 255, 255, 1, 0, 0, 16'hFFFF, 1), 0);
    send_voxel(vox(16'hFFFF, 0, 0, 5, 5, 5, 5, 1), 0);
    send_voxel(vox(256, 0, 0, 5, 5, 5, 5, 0), 0);
    send_voxel(vox(0, 0, 0, 0, 9, 0, 9, 1), 0);
    send_voxel(vox(0, 16'h8000, 0, 5, 5, 5, 5, 0), 0);
    send_voxel(vox(0, 0, 16'h7FFF, 5, 5, 5, 5, 0), 0);
    send_voxel(vox(3, 4, 5, 5, 5, 5, 5, 1), 0);
    send_voxel(vox(7, 8, 9, 0, 100, 16'h00FF, 200, 0), 1);
    send_voxel(vox(10, 11, 12, 7, 16'h1234, 0, 16'hAAAA, 0), 0);
    send_voxel(vox(10, 11, 12, 3, 1, 16'h5555, 16'hAAAA, 0), 0);
    v = vox(1, 2, 3, 16'h0100, 16'h0300, 16'h0200, 16'h0100, 1);
    v.prior = '0;
    v.heur = '0;
    v.travel = '0;
    send_voxel(v, 2);
    drain();

    // largest grid, weight exactly one
    set_grid(32767, 32767, 32767, 65536);
    send_voxel(vox(16'h7FFE, 16'h7FFE, 16'h7FFE, 16'hFFFF, 16'hFFFF, 1, 1, 1), 0);
    send_voxel(vox(16'h7FFF, 0, 0, 1, 1, 1, 1, 1), 0);
    random_states(350);
    drain();

    // smallest grid, weight zero
    set_grid(1, 1, 1, 0);
    send_voxel(vox(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1), 0);
    send_voxel(vox(1, 0, 0, 1, 1, 1, 1, 1), 0);
    random_states(300);
    drain();

    // uneven grid, weight above one clips
    set_grid(100, 2000, 7, 131071);
    random_states(350);
    drain();

    // zero size along one axis: every state rejected
    set_grid(300, 300, 0, 65535);
    random_states(60);
    drain();

    // random settings
    set_grid($urandom_range(1, 32767), $urandom_range(1, 4000), $urandom_range(1, 64),
             $urandom_range(1, 65535));
    random_states(350);
    drain();
    set_grid(256, 256, 256, 32768);
    random_states(340);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/dvca_pkg.sv
rtl/dvca_front.sv
rtl/dvca_fifo.sv
rtl/dvca_back.sv
rtl/deformable_voxel_cost_accumulator.sv
rtl/dvca_checker.sv
bench/deformable_voxel_cost_accumulator_test.sv
